// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the killer move table RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/kmt_pkg.sv =====
// Package for the killer move table: sizes, command and outcome codes,
// transaction and row types. No dependencies.
`default_nettype none

package kmt_pkg;

	localparam int PLY_DEPTH = 64;
	localparam int PLY_AW    = $clog2(PLY_DEPTH);
	localparam int MOVE_BITS = 16;
	localparam int PLY_W     = 6;
	localparam int MOVE_W    = 16;
	localparam int COUNT_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	// Low MOVE_BITS bits of the move field are significant
	localparam logic [MOVE_W-1:0] MOVE_MASK =
		(MOVE_BITS >= MOVE_W) ? {MOVE_W{1'b1}} : MOVE_W'((64'd1 << MOVE_BITS) - 64'd1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AGED_COUNT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ENABLE = 1'd1;

	typedef enum logic [1:0] {
		CMD_UPDATE = 2'd0,
		CMD_AGE    = 2'd1,
		CMD_LOAD   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		OUT_HIT0  = 3'd0,
		OUT_HIT1  = 3'd1,
		OUT_REPL0 = 3'd2,
		OUT_REPL1 = 3'd3,
		OUT_OTHER = 3'd4
	} outcome_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [PLY_W-1:0]  ply;
		logic [MOVE_W-1:0] move;
	} req_t;

	typedef struct packed {
		logic [MOVE_W-1:0] first_killer;
		logic [MOVE_W-1:0] second_killer;
		outcome_t          outcome;
	} rsp_t;

	// Both slots of one ply, stored as one memory word
	typedef struct packed {
		logic [MOVE_W-1:0]  move0;
		logic [COUNT_W-1:0] cnt0;
		logic [MOVE_W-1:0]  move1;
		logic [COUNT_W-1:0] cnt1;
	} row_t;

	typedef struct packed {
		logic wr;   // write the updated row back
		logic clr;  // zero the whole table
	} upd_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/kmt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module kmt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/kmt_slot_logic.sv =====
// Per-command update of the two killer slots of one ply and the result
// it produces. Depends on kmt_pkg.
`default_nettype none

module kmt_slot_logic (
	input  wire kmt_pkg::req_t                    req,
	input  wire logic                             ply_ok,
	input  wire kmt_pkg::row_t                    row,
	input  wire logic [kmt_pkg::COUNT_W-1:0]      aged_count,
	input  wire logic                             clear_enable,
	output kmt_pkg::row_t                         new_row,
	output kmt_pkg::upd_ctrl_t                    ctrl,
	output kmt_pkg::rsp_t                         rsp
);
	import kmt_pkg::*;

	logic [MOVE_W-1:0] mv;
	logic              hit0;
	logic              hit1;
	outcome_t          outcome;

	assign mv   = req.move & MOVE_MASK;
	assign hit0 = (mv == row.move0);
	assign hit1 = (mv == row.move1);

	// Slot update by command
	always_comb begin
		new_row = row;
		outcome = OUT_OTHER;
		unique case (req.cmd)
			CMD_UPDATE: begin
				priority if (hit0) begin
					if (row.cnt0 != COUNT_MAX) new_row.cnt0 = row.cnt0 + COUNT_W'(1);
					outcome = OUT_HIT0;
				end else if (hit1) begin
					if (row.cnt1 != COUNT_MAX) new_row.cnt1 = row.cnt1 + COUNT_W'(1);
					outcome = OUT_HIT1;
				end else if (row.cnt0 < row.cnt1) begin
					new_row.move0 = mv;
					new_row.cnt0  = COUNT_W'(1);
					outcome       = OUT_REPL0;
				end else begin
					new_row.move1 = mv;
					new_row.cnt1  = COUNT_W'(1);
					outcome       = OUT_REPL1;
				end
			end
			CMD_AGE: begin
				if (row.cnt0 > aged_count) new_row.cnt0 = aged_count;
				if (row.cnt1 > aged_count) new_row.cnt1 = aged_count;
			end
			CMD_LOAD: begin
				// zero move marks the end of the PV
				if (mv != '0) begin
					new_row.move0 = mv;
					new_row.cnt0  = aged_count;
				end
			end
			CMD_CLEAR: begin
				new_row = row;
			end
		endcase
	end

	// Write-back control
	always_comb begin
		ctrl.clr = (req.cmd == CMD_CLEAR) && clear_enable;
		ctrl.wr  = (req.cmd != CMD_CLEAR) && ply_ok;
	end

	// Result transaction
	always_comb begin
		if (!ply_ok || ctrl.clr) begin
			rsp.first_killer  = '0;
			rsp.second_killer = '0;
		end else begin
			rsp.first_killer  = new_row.move0;
			rsp.second_killer = new_row.move1;
		end
		rsp.outcome = ply_ok ? outcome : OUT_OTHER;
	end

endmodule

`default_nettype wire

// ===== rtl/killer_move_table.sv =====
// Killer move table: two killer slots (move and use count) per search ply,
// updated by update, age, PV load and clear commands. Depends on kmt_pkg,
// kmt_ram, kmt_slot_logic and assert_macros.svh.
`default_nettype none

// One request transaction is taken every cycle and each gives one result
// transaction: at the accepting edge the ply row memory is read into its
// output register and the request enters stage 1; when stage 1 moves on,
// the slots are updated and the result lands in the result register while the
// row is written back to the row memory. A request accepted at the edge
// that writes back its ply is served from a bypass register. One valid bit per
// ply stands for reset and clear, so the table is usable straight out of
// reset with no clearing pass, and a clear zeroes every valid bit together.
// Throughput drops only when the result side stalls.
module killer_move_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire kmt_pkg::req_t                  req_item,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output kmt_pkg::rsp_t                       rsp_item,
	input  wire logic                           cfg_we,
	input  wire logic [kmt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kmt_pkg::CFG_W-1:0]      cfg_wdata
);
	import kmt_pkg::*;

	`include "assert_macros.svh"

	logic [COUNT_W-1:0]   aged_count_q;
	logic                 clear_enable_q;
	logic [PLY_DEPTH-1:0] row_valid_q;

	logic                 req_acc;
	logic                 adv;
	logic [PLY_AW-1:0]    req_addr;

	logic                 s1_valid_q;
	req_t                 s1_item;
	logic [PLY_AW-1:0]    s1_addr;
	logic                 s1_ply_ok;
	logic                 row_vld_s1;
	logic                 byp_hit_s1;
	row_t                 byp_row_s1;

	row_t                 ram_rdata;
	row_t                 cur_row;
	row_t                 new_row;
	upd_ctrl_t            ctrl;
	rsp_t                 rsp_next;
	logic                 wr_now;
	logic                 clr_now;

	logic                 rsp_valid_q;
	rsp_t                 rsp_item_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aged_count_q   <= COUNT_W'(1);
			clear_enable_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AGED_COUNT:   aged_count_q   <= cfg_wdata[COUNT_W-1:0];
				CFG_CLEAR_ENABLE: clear_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the result register is free or taken
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = s1_valid_q && !adv;
	assign req_acc   = req_valid && !req_stall;
	assign req_addr  = PLY_AW'(req_item.ply);

	// Row memory, read at accept, written when stage 1 retires
	kmt_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (PLY_DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (wr_now),
		.waddr (s1_addr),
		.wdata (new_row),
		.re    (req_acc),
		.raddr (req_addr),
		.rdata (ram_rdata)
	);

	assign s1_addr   = PLY_AW'(s1_item.ply);
	assign s1_ply_ok = ({3'b000, s1_item.ply} < 9'(PLY_DEPTH));
	assign wr_now    = s1_valid_q && adv && ctrl.wr;
	assign clr_now   = s1_valid_q && adv && ctrl.clr;

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_hit_s1 <= 1'b0;
			row_vld_s1 <= 1'b0;
		end else if (req_acc) begin
			s1_valid_q <= 1'b1;
			byp_hit_s1 <= wr_now && (s1_addr == req_addr);
			row_vld_s1 <= row_valid_q[req_addr] && !clr_now;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			s1_item    <= req_item;
			byp_row_s1 <= new_row;
		end
	end

	// Row as left by earlier transactions
	always_comb begin
		priority if (byp_hit_s1) cur_row = byp_row_s1;
		else if (row_vld_s1)     cur_row = ram_rdata;
		else                     cur_row = '0;
	end

	kmt_slot_logic u_slot_logic (
		.req          (s1_item),
		.ply_ok       (s1_ply_ok),
		.row          (cur_row),
		.aged_count   (aged_count_q),
		.clear_enable (clear_enable_q),
		.new_row      (new_row),
		.ctrl         (ctrl),
		.rsp          (rsp_next)
	);

	// Per-ply valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (clr_now) begin
			row_valid_q <= '0;
		end else if (wr_now) begin
			row_valid_q[s1_addr] <= 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			rsp_item_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	// A write-back always comes with a result entering the output register
	`ASSERT_NEXT(a_wr_gives_rsp, wr_now, rsp_valid_q, "row write without a result")
	// A blocked stage 1 keeps its transaction
	`ASSERT_NEXT(a_s1_hold, s1_valid_q && !adv, s1_valid_q && $stable(s1_item),
		"stage 1 lost its transaction while blocked")
	// A clear leaves no ply valid
	`ASSERT_NEXT(a_clear_all, clr_now, row_valid_q == '0, "clear left valid rows")
	// The bypass is only armed for a live transaction
	`ASSERT_SAME(a_byp_live, byp_hit_s1 && !s1_valid_q, 1'b0 == 1'b1,
		"bypass set without stage 1 transaction")

endmodule

`default_nettype wire

// ===== bench/killer_move_table_checker.sv =====
// Checker for the killer move table: watches the request, result and config
// ports, predicts each result from its own copy of the table and compares.
// Depends on kmt_pkg.
`default_nettype none

module killer_move_table_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	input  wire logic                           req_stall,
	input  wire kmt_pkg::req_t                  req_item,
	input  wire logic                           rsp_valid,
	input  wire logic                           rsp_stall,
	input  wire kmt_pkg::rsp_t                  rsp_item,
	input  wire logic                           cfg_we,
	input  wire logic [kmt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kmt_pkg::CFG_W-1:0]      cfg_wdata,
	output int unsigned                         fail_count,
	output int unsigned                         outstanding
);
	import kmt_pkg::*;

	localparam int SLOTS = 2 * PLY_DEPTH;

	// Shadow table and config
	logic [MOVE_W-1:0]  km_move  [SLOTS];
	logic [COUNT_W-1:0] km_count [SLOTS];
	logic [COUNT_W-1:0] aged_count;
	logic               clear_en;

	rsp_t        pending_killers[$];
	rsp_t        want;
	int unsigned fails;

	function automatic void wipe_table();
		for (int i = 0; i < SLOTS; i++) begin
			km_move[i]  = '0;
			km_count[i] = '0;
		end
	endfunction

	// Apply one command to the shadow table, return the killers it leaves
	function automatic rsp_t killers_after_cmd(req_t r);
		int unsigned       a;
		int unsigned       b;
		logic              in_range;
		logic [MOVE_W-1:0] mv;
		rsp_t              res;
		in_range    = int'(r.ply) < PLY_DEPTH;
		a           = in_range ? 2 * int'(r.ply) : 0;
		b           = a + 1;
		mv          = r.move & MOVE_MASK;
		res.outcome = OUT_OTHER;
		if (r.cmd == CMD_CLEAR) begin
			if (clear_en)
				wipe_table();
		end else if (in_range) begin
			case (r.cmd)
				CMD_UPDATE: begin
					if (mv == km_move[a]) begin
						if (km_count[a] != COUNT_MAX)
							km_count[a] = km_count[a] + COUNT_W'(1);
						res.outcome = OUT_HIT0;
					end else if (mv == km_move[b]) begin
						if (km_count[b] != COUNT_MAX)
							km_count[b] = km_count[b] + COUNT_W'(1);
						res.outcome = OUT_HIT1;
					end else if (km_count[a] < km_count[b]) begin
						km_move[a]  = mv;
						km_count[a] = COUNT_W'(1);
						res.outcome = OUT_REPL0;
					end else begin
						km_move[b]  = mv;
						km_count[b] = COUNT_W'(1);
						res.outcome = OUT_REPL1;
					end
				end
				CMD_AGE: begin
					if (km_count[a] > aged_count)
						km_count[a] = aged_count;
					if (km_count[b] > aged_count)
						km_count[b] = aged_count;
				end
				CMD_LOAD: begin
					// zero move ends the PV: no write
					if (mv != '0) begin
						km_move[a]  = mv;
						km_count[a] = aged_count;
					end
				end
				default: ;
			endcase
		end
		res.first_killer  = in_range ? km_move[a] : '0;
		res.second_killer = in_range ? km_move[b] : '0;
		return res;
	endfunction

	task automatic report(string what);
		fails++;
		if (fails <= 10)
			$display("%0t mismatch: %s", $time, what);
	endtask

	// Result compare first, then the new expectation, then config writes
	always @(posedge clk) begin
		if (!arst_n) begin
			wipe_table();
			aged_count = COUNT_W'(1);
			clear_en   = 1'b1;
			pending_killers.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_killers.size() == 0) begin
					report($sformatf("unexpected result first=%h second=%h outcome=%0d",
						rsp_item.first_killer, rsp_item.second_killer, rsp_item.outcome));
				end else begin
					want = pending_killers.pop_front();
					if (rsp_item.first_killer !== want.first_killer ||
					    rsp_item.second_killer !== want.second_killer ||
					    rsp_item.outcome !== want.outcome)
						report($sformatf("expected %h %h %0d, got %h %h %0d",
							want.first_killer, want.second_killer, want.outcome,
							rsp_item.first_killer, rsp_item.second_killer,
							rsp_item.outcome));
				end
			end
			if (req_valid && !req_stall)
				pending_killers.push_back(killers_after_cmd(req_item));
			if (cfg_we) begin
				case (cfg_index)
					CFG_AGED_COUNT:   aged_count = cfg_wdata[COUNT_W-1:0];
					CFG_CLEAR_ENABLE: clear_en   = cfg_wdata[0];
					default: ;
				endcase
			end
		end
		outstanding <= pending_killers.size();
		fail_count  <= fails;
	end

endmodule

`default_nettype wire

// ===== bench/killer_move_table_tb.sv =====
// Testbench top for the killer move table: clock, reset, directed and random
// command stimulus, result-side stall bursts and the final verdict.
// Depends on kmt_pkg, killer_move_table and killer_move_table_checker.
`default_nettype none

module killer_move_table_tb;
	import kmt_pkg::*;

	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int CYCLE_LIMIT     = 400000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req_item  = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp_item;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	int unsigned       fail_count;
	int unsigned       outstanding;
	int unsigned       cycle_count = 0;
	logic              idle_on     = 1'b1;
	logic [PLY_W-1:0]  hot_base    = '0;
	logic [MOVE_W-1:0] move_pool [6];

	killer_move_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	killer_move_table_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_item    (req_item),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_item    (rsp_item),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Timeout guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL killer_move_table");
			$finish;
		end
	end

	// Result-side stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic req_t mk(cmd_t c, int unsigned p, logic [MOVE_W-1:0] mv);
		req_t r;
		r.cmd  = c;
		r.ply  = PLY_W'(p);
		r.move = mv;
		return r;
	endfunction

	// Mostly updates on a few hot plies with moves from a small pool
	function automatic req_t rand_cmd_item();
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 64)
			r.cmd = CMD_UPDATE;
		else if (pick < 80)
			r.cmd = CMD_AGE;
		else if (pick < 98)
			r.cmd = CMD_LOAD;
		else
			r.cmd = CMD_CLEAR;
		if ($urandom_range(0, 3) != 0)
			r.ply = hot_base + PLY_W'($urandom_range(0, 3));
		else
			r.ply = PLY_W'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 6)
			r.move = move_pool[$urandom_range(0, 5)];
		else if (pick == 6)
			r.move = '0;
		else
			r.move = MOVE_W'($urandom);
		return r;
	endfunction

	// Send one request transaction, with an occasional idle burst first
	task automatic send_cmd(req_t r);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= r;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset config (aged count 1, clear enabled)
		send_cmd(mk(CMD_UPDATE, 0, 16'h0000));   // zero move hits the empty slot 0
		send_cmd(mk(CMD_UPDATE, 0, 16'hFFFF));   // slot 0 not less used: replace slot 1
		send_cmd(mk(CMD_UPDATE, 0, 16'hFFFF));   // hit slot 1
		send_cmd(mk(CMD_UPDATE, 0, 16'h1234));   // slot 0 less used: replace slot 0
		send_cmd(mk(CMD_AGE, 0, 16'h0000));
		send_cmd(mk(CMD_LOAD, 63, 16'h0000));    // end of PV, no write
		send_cmd(mk(CMD_LOAD, 63, 16'hA5A5));
		send_cmd(mk(CMD_UPDATE, 63, 16'hA5A5));
		send_cmd(mk(CMD_UPDATE, 63, 16'h5A5A));
		send_cmd(mk(CMD_CLEAR, 17, 16'hFFFF));
		send_cmd(mk(CMD_UPDATE, 63, 16'h5A5A));
		send_cmd(mk(CMD_UPDATE, 0, 16'h1234));
		drain();

		// Directed: full aged count, saturation, clear disabled
		write_cfg(CFG_AGED_COUNT, 16'hFFFF);
		write_cfg(CFG_CLEAR_ENABLE, 16'hFFFE);
		send_cmd(mk(CMD_LOAD, 1, 16'h0F0F));
		send_cmd(mk(CMD_UPDATE, 1, 16'h0F0F));   // saturated hit
		send_cmd(mk(CMD_UPDATE, 1, 16'h0F0F));
		send_cmd(mk(CMD_AGE, 1, 16'h0000));
		send_cmd(mk(CMD_CLEAR, 42, 16'h0000));   // ignored
		send_cmd(mk(CMD_UPDATE, 1, 16'h0F0F));
		send_cmd(mk(CMD_UPDATE, 1, 16'hF0F0));
		drain();
		write_cfg(CFG_AGED_COUNT, 16'h0000);
		send_cmd(mk(CMD_AGE, 1, 16'h0000));      // both counts to zero
		send_cmd(mk(CMD_UPDATE, 1, 16'h3C3C));
		send_cmd(mk(CMD_LOAD, 2, 16'h8001));
		send_cmd(mk(CMD_UPDATE, 2, 16'h7FFE));
		drain();

		// Random phases, each under its own config
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_cfg(CFG_AGED_COUNT, 16'h0000);
				1: write_cfg(CFG_AGED_COUNT, 16'hFFFF);
				2: write_cfg(CFG_AGED_COUNT, CFG_W'($urandom_range(1, 8)));
				3: write_cfg(CFG_AGED_COUNT, CFG_W'($urandom));
				4: write_cfg(CFG_AGED_COUNT, 16'h0002);
				default: write_cfg(CFG_AGED_COUNT, CFG_W'($urandom_range(1, 4)));
			endcase
			write_cfg(CFG_CLEAR_ENABLE, (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'(p % 2));
			idle_on  <= (p < PHASES - 1) && (p != 2);
			hot_base <= PLY_W'($urandom);
			for (int k = 0; k < 6; k++)
				move_pool[k] = MOVE_W'($urandom);
			@(posedge clk);
			repeat (ITEMS_PER_PHASE)
				send_cmd(rand_cmd_item());
			drain();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS killer_move_table");
		else
			$display("FAIL killer_move_table");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/kmt_pkg.sv
rtl/kmt_ram.sv
rtl/kmt_slot_logic.sv
rtl/killer_move_table.sv
bench/killer_move_table_checker.sv
bench/killer_move_table_tb.sv
